// ===== sv/tlpq_pkg.sv =====
// Shared constants and types for the three-level priority queue.
// Used by tlpq_ram's users and by three_level_priority_queue_top; no dependencies.
package tlpq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_LEVELS  = 3;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W       = 2;
    localparam int ADDR_W      = PTR_W + LVL_W;
    localparam int RAM_DEPTH   = 2 ** ADDR_W;
    localparam int ID_W        = 32;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_W        = 2 + ID_W + 2;
    localparam int IN_DATA_W   = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = 3 + ID_W + 2;
    localparam int OUT_DATA_W  = ((OUT_W + 7) / 8) * 8;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [LVL_W-1:0] t_lvl;

    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_SEARCH = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_BADPRI   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    localparam t_lvl LVL_HIGH = 2'd0;
    localparam t_lvl LVL_MED  = 2'd1;
    localparam t_lvl LVL_LOW  = 2'd2;

    // A level's position in the shared entry memory.
    function automatic logic [ADDR_W-1:0] entry_addr(input t_lvl lvl, input t_ptr pos);
        entry_addr = {lvl, pos};
    endfunction

    function automatic t_ptr next_pos(input t_ptr p);
        next_pos = (p == t_ptr'(QUEUE_DEPTH - 1)) ? '0 : p + t_ptr'(1);
    endfunction

endpackage

// ===== sv/three_level_priority_queue_top.sv =====
// Three-level strict priority ticket queue; depends on tlpq_pkg and tlpq_ram.
// One request is worked on at a time. From acceptance, push and invalid modes
// pass through S_EXEC and S_DONE, pop through S_EXEC, S_POPRD and S_DONE, and
// search through S_EXEC, S_SRCH and S_DONE, with at most one entry memory read
// per cycle while scanning the queues. Reset (synchronous, active low) clears
// head, tail and count pointers and the output valid; the entry memory is not cleared and needs no clearing pass.
module three_level_priority_queue_top
    import tlpq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // mode[1:0], ticket_id[33:2], priority_req[35:34], zero padding above
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // status[2:0], result_id[34:3], result_priority[36:35], zero padding above
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_POPRD = 5'b00100,
        S_SRCH  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Captured request
    logic [1:0]      r_mode;
    logic [ID_W-1:0] r_id;
    logic [1:0]      r_pri;

    // Queue pointers
    t_ptr r_head [NUM_LEVELS];
    t_ptr r_tail [NUM_LEVELS];
    t_cnt r_count [NUM_LEVELS];
    t_ptr n_head [NUM_LEVELS];
    t_ptr n_tail [NUM_LEVELS];
    t_cnt n_count [NUM_LEVELS];

    // Search scan state
    t_lvl r_lvl, n_lvl;
    t_ptr r_pos, n_pos;
    t_cnt r_k, n_k;
    logic r_cmp_valid, n_cmp_valid;
    t_lvl r_cmp_lvl, n_cmp_lvl;
    logic r_issue_done, n_issue_done;

    // Pending result
    t_status         r_res_status, n_res_status;
    logic [ID_W-1:0] r_res_id, n_res_id;
    logic [1:0]      r_res_pri, n_res_pri;

    // Output register
    logic            r_out_valid, n_out_valid;
    t_status         r_out_status, n_out_status;
    logic [ID_W-1:0] r_out_id, n_out_id;
    logic [1:0]      r_out_pri, n_out_pri;

    // Memory port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ID_W-1:0]   ram_rdata;

    logic in_fire;
    t_lvl push_lvl;
    t_lvl pop_lvl;
    logic pop_any;

    tlpq_ram #(
        .WIDTH (ID_W),
        .DEPTH (RAM_DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_id),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign push_lvl   = t_lvl'(r_pri - 2'd1);

    always_comb begin
        pop_any = 1'b1;
        if (r_count[LVL_HIGH] != '0) begin
            pop_lvl = LVL_HIGH;
        end else if (r_count[LVL_MED] != '0) begin
            pop_lvl = LVL_MED;
        end else begin
            pop_lvl = LVL_LOW;
            pop_any = (r_count[LVL_LOW] != '0);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_lvl        = r_lvl;
        n_pos        = r_pos;
        n_k          = r_k;
        n_cmp_valid  = 1'b0;
        n_cmp_lvl    = r_cmp_lvl;
        n_issue_done = r_issue_done;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_pri    = r_res_pri;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_pri    = r_out_pri;
        ram_we       = 1'b0;
        ram_waddr    = entry_addr(push_lvl, r_tail[push_lvl]);
        ram_raddr    = entry_addr(r_lvl, r_pos);

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_status = ST_OK;
                n_res_id     = '0;
                n_res_pri    = '0;
                n_state      = S_DONE;
                unique case (r_mode)
                    MODE_PUSH: begin
                        if (r_pri == 2'd0) begin
                            n_res_status = ST_BADPRI;
                        end else if (r_count[push_lvl] >= t_cnt'(QUEUE_DEPTH)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            ram_we             = 1'b1;
                            n_tail[push_lvl]   = next_pos(r_tail[push_lvl]);
                            n_count[push_lvl]  = r_count[push_lvl] + t_cnt'(1);
                        end
                    end
                    MODE_POP: begin
                        if (!pop_any) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            ram_raddr        = entry_addr(pop_lvl, r_head[pop_lvl]);
                            n_head[pop_lvl]  = next_pos(r_head[pop_lvl]);
                            n_count[pop_lvl] = r_count[pop_lvl] - t_cnt'(1);
                            n_res_pri        = pop_lvl + 2'd1;
                            n_state          = S_POPRD;
                        end
                    end
                    MODE_SEARCH: begin
                        n_lvl        = LVL_HIGH;
                        n_pos        = r_head[LVL_HIGH];
                        n_k          = '0;
                        n_issue_done = 1'b0;
                        n_state      = S_SRCH;
                    end
                    default: begin
                    end
                endcase
            end
            S_POPRD: begin
                n_res_id = ram_rdata;
                n_state  = S_DONE;
            end
            S_SRCH: begin
                // Reads are issued at most one per cycle; each result is compared in the cycle after its read.
                if (r_cmp_valid && ram_rdata == r_id) begin
                    n_res_status = ST_OK;
                    n_res_id     = r_id;
                    n_res_pri    = r_cmp_lvl + 2'd1;
                    n_state      = S_DONE;
                end else if (r_issue_done && !r_cmp_valid) begin
                    n_res_status = ST_NOTFOUND;
                    n_res_id     = '0;
                    n_res_pri    = '0;
                    n_state      = S_DONE;
                end else if (!r_issue_done) begin
                    if (r_k < r_count[r_lvl]) begin
                        n_cmp_valid = 1'b1;
                        n_cmp_lvl   = r_lvl;
                        n_k         = r_k + t_cnt'(1);
                        n_pos       = next_pos(r_pos);
                    end else if (r_lvl == LVL_LOW) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_lvl = r_lvl + 2'd1;
                        n_pos = r_head[r_lvl + 2'd1];
                        n_k   = '0;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_id     = r_res_id;
                    n_out_pri    = r_res_pri;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_cmp_valid  <= 1'b0;
            r_issue_done <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_cmp_valid  <= n_cmp_valid;
            r_issue_done <= n_issue_done;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode <= i_s_tdata[1:0];
            r_id   <= i_s_tdata[33:2];
            r_pri  <= i_s_tdata[35:34];
        end
        r_lvl        <= n_lvl;
        r_pos        <= n_pos;
        r_k          <= n_k;
        r_cmp_lvl    <= n_cmp_lvl;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_pri    <= n_res_pri;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_pri    <= n_out_pri;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - OUT_W){1'b0}}, r_out_pri, r_out_id, r_out_status};

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[LVL_HIGH] <= t_cnt'(QUEUE_DEPTH) && r_count[LVL_MED] <= t_cnt'(QUEUE_DEPTH)
        && r_count[LVL_LOW] <= t_cnt'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == S_EXEC)
        else $error("accepted request did not start execution");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status != ST_OK |-> r_out_id == '0 && r_out_pri == 2'd0)
        else $error("failed request carries an id or priority");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POPRD |-> $past(pop_any))
        else $error("pop read from an empty queue");

endmodule

// ===== sv/tlpq_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; contents are not reset.
module tlpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
